// File: sv/jac_pkg.sv
// Shared widths, register indexes and constants for the joystick conditioner.
`timescale 1ns / 1ps

package jac_pkg;

    localparam int RAW_W   = 16;
    localparam int VAL_W   = 11;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int CTR_W   = 15;
    localparam int DZ_W    = 14;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int EXT_W   = 18;
    localparam int DIFF_W  = 15;
    localparam int QUO_W   = 10;
    localparam int NUM_W   = DIFF_W + QUO_W;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 32;

    localparam logic [IDX_W-1:0] CFG_CENTER   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DEADZONE = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RAW_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RAW_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE = 3'd4;

    localparam logic [CTR_W-1:0]   RST_CENTER   = 15'd11870;
    localparam logic [DZ_W-1:0]    RST_DEADZONE = 14'd600;
    localparam logic [CTR_W-1:0]   RST_RAW_MIN  = 15'd0;
    localparam logic [CTR_W-1:0]   RST_RAW_MAX  = 15'd23500;
    localparam logic [DELAY_W-1:0] RST_DEBOUNCE = 16'd50;

    localparam logic [QUO_W-1:0] SCALE      = 10'd999;
    localparam logic [VAL_W-1:0] VAL_CENTER = 11'd1000;
    localparam logic [VAL_W-1:0] VAL_UPPER  = 11'd1001;
    localparam logic [VAL_W-1:0] VAL_MAX    = 11'd2000;

endpackage

// File: sv/jac_div.sv
// Restoring divider, one quotient bit per cycle, shared by both axes.
`timescale 1ns / 1ps

module jac_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jac_pkg::NUM_W-1:0]   i_num,
    input  logic [jac_pkg::DIFF_W-1:0]  i_den,
    output logic                        o_done,
    output logic [jac_pkg::QUO_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(jac_pkg::QUO_W + 1);

    logic [jac_pkg::NUM_W-1:0] r_rem;
    logic [jac_pkg::NUM_W-1:0] r_dsh;
    logic [jac_pkg::QUO_W-1:0] r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic                      n_ge;

    // The quotient is known to stay below 2^QUO_W, so the divisor starts
    // shifted up by QUO_W-1 and walks down one bit per step.
    assign n_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {1'b0, i_den, {(jac_pkg::QUO_W - 1){1'b0}}};
            r_quo  <= '0;
            r_cnt  <= CNT_W'(jac_pkg::QUO_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            if (n_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quo  <= {r_quo[jac_pkg::QUO_W-2:0], n_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: sv/jac_debounce.sv
// Timestamp debounce and release detection for one button.
`timescale 1ns / 1ps

module jac_debounce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_level,
    input  logic [jac_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [jac_pkg::DELAY_W-1:0]  i_delay_ms,
    output logic                         o_pressed,
    output logic                         o_click
);

    logic                        r_prev;
    logic [jac_pkg::TIME_W-1:0]  r_stamp;
    logic                        r_stable;
    logic                        r_click;
    logic                        n_pressed;
    logic [jac_pkg::TIME_W-1:0]  n_stamp;
    logic [jac_pkg::TIME_W-1:0]  n_elapsed;
    logic                        n_stable;

    // The pin is pulled up, so a low level means the button is held.
    always_comb begin
        n_pressed = ~i_level;
        n_stamp   = (n_pressed != r_prev) ? i_now_ms : r_stamp;
        n_elapsed = i_now_ms - n_stamp;
        n_stable  = (n_elapsed > {{(jac_pkg::TIME_W - jac_pkg::DELAY_W){1'b0}}, i_delay_ms})
                    ? n_pressed : r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_stamp  <= '0;
            r_stable <= 1'b0;
            r_click  <= 1'b0;
        end else if (i_en) begin
            r_prev   <= n_pressed;
            r_stamp  <= n_stamp;
            r_stable <= n_stable;
            r_click  <= r_stable & ~n_stable;
        end
    end

    assign o_pressed = r_stable;
    assign o_click   = r_click;

endmodule

// File: sv/joystick_axis_and_button_conditioner.sv
// An input beat is taken in S_IDLE; each axis then goes through S_PREP, and an axis outside
// the center band with a positive span also goes through S_LOAD and S_DIV, before S_DONE
// loads the result beat. A new beat is taken only back in S_IDLE, once the result is loaded;
// the divided axes go through the shared 10-step divider one after the other.
// Reset (synchronous, active low) restores the default calibration, clears the button
// debounce state and empties the output register.
`timescale 1ns / 1ps

module joystick_axis_and_button_conditioner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input beat, from bit 0: left_axis_raw[15:0], right_axis_raw[15:0],
    // left_button_level, right_button_level, now_ms[31:0], zero fill.
    input  logic [jac_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // Result beat, from bit 0: left_axis_value[10:0], right_axis_value[10:0],
    // left_pressed, right_pressed, left_click, right_click, zero fill.
    output logic [jac_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_wr_en,
    input  logic [jac_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [jac_pkg::CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_axis_sel;
    logic   r_out_valid;

    logic [jac_pkg::CTR_W-1:0]   r_center;
    logic [jac_pkg::DZ_W-1:0]    r_dead_zone;
    logic [jac_pkg::CTR_W-1:0]   r_raw_min;
    logic [jac_pkg::CTR_W-1:0]   r_raw_max;
    logic [jac_pkg::DELAY_W-1:0] r_delay;

    logic signed [jac_pkg::RAW_W-1:0] r_left_raw;
    logic signed [jac_pkg::RAW_W-1:0] r_right_raw;
    logic signed [jac_pkg::EXT_W-1:0] r_lo;
    logic signed [jac_pkg::EXT_W-1:0] r_hi;
    logic signed [jac_pkg::EXT_W-1:0] r_den_lo;
    logic signed [jac_pkg::EXT_W-1:0] r_den_hi;
    logic [jac_pkg::DIFF_W-1:0]       r_diff;
    logic [jac_pkg::DIFF_W-1:0]       r_den;
    logic                             r_upper;
    logic [jac_pkg::VAL_W-1:0]        r_left_val;
    logic [jac_pkg::VAL_W-1:0]        r_right_val;
    logic [jac_pkg::OUT_W-1:0]        r_out_data;

    logic                             n_accept;
    logic                             n_out_take;
    logic                             n_out_load;
    logic signed [jac_pkg::EXT_W-1:0] n_lo;
    logic signed [jac_pkg::EXT_W-1:0] n_hi;
    logic signed [jac_pkg::EXT_W-1:0] n_min;
    logic signed [jac_pkg::EXT_W-1:0] n_max;
    logic signed [jac_pkg::EXT_W-1:0] n_v;
    logic                             n_below;
    logic                             n_fixed;
    logic signed [jac_pkg::EXT_W-1:0] n_diff;
    logic [jac_pkg::DIFF_W-1:0]       n_den;
    logic [jac_pkg::NUM_W-1:0]        n_num;
    logic [jac_pkg::VAL_W-1:0]        n_div_val;

    logic                             div_start;
    logic                             div_done;
    logic [jac_pkg::QUO_W-1:0]        div_quo;
    logic                             left_pressed;
    logic                             right_pressed;
    logic                             left_click;
    logic                             right_click;

    function automatic logic signed [jac_pkg::EXT_W-1:0] EXT_SEXT(
        input logic signed [jac_pkg::RAW_W-1:0] raw
    );
        return {{(jac_pkg::EXT_W - jac_pkg::RAW_W){raw[jac_pkg::RAW_W-1]}}, raw};
    endfunction

    assign n_accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign n_out_take = r_out_valid & i_m_axis_tready;
    assign n_out_load = (r_state == S_DONE) & (~r_out_valid | i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= jac_pkg::RST_CENTER;
            r_dead_zone <= jac_pkg::RST_DEADZONE;
            r_raw_min   <= jac_pkg::RST_RAW_MIN;
            r_raw_max   <= jac_pkg::RST_RAW_MAX;
            r_delay     <= jac_pkg::RST_DEBOUNCE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                jac_pkg::CFG_CENTER:   r_center    <= i_cfg_wdata[jac_pkg::CTR_W-1:0];
                jac_pkg::CFG_DEADZONE: r_dead_zone <= i_cfg_wdata[jac_pkg::DZ_W-1:0];
                jac_pkg::CFG_RAW_MIN:  r_raw_min   <= i_cfg_wdata[jac_pkg::CTR_W-1:0];
                jac_pkg::CFG_RAW_MAX:  r_raw_max   <= i_cfg_wdata[jac_pkg::CTR_W-1:0];
                jac_pkg::CFG_DEBOUNCE: r_delay     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Band edges and spans depend only on calibration, so they are formed once per beat.
    always_comb begin
        n_min = $signed({3'b000, r_raw_min});
        n_max = $signed({3'b000, r_raw_max});
        n_lo  = $signed({3'b000, r_center}) - $signed({4'b0000, r_dead_zone});
        n_hi  = $signed({3'b000, r_center}) + $signed({4'b0000, r_dead_zone});
    end

    // Classify the selected sample and form the clamped offset and the span.
    always_comb begin
        n_v     = r_axis_sel ? EXT_SEXT(r_right_raw) : EXT_SEXT(r_left_raw);
        n_below = (n_v < r_lo);
        if (n_below) begin
            n_fixed = (r_den_lo <= 0);
            n_diff  = (n_v < n_min) ? '0 : n_v - n_min;
            n_den   = r_den_lo[jac_pkg::DIFF_W-1:0];
        end else begin
            n_fixed = (r_den_hi <= 0) || (n_v <= r_hi);
            n_diff  = (n_v > n_max) ? r_den_hi : n_v - r_hi;
            n_den   = r_den_hi[jac_pkg::DIFF_W-1:0];
        end
    end

    assign n_num     = {{jac_pkg::QUO_W{1'b0}}, r_diff} * {{jac_pkg::DIFF_W{1'b0}}, jac_pkg::SCALE};
    assign n_div_val = r_upper ? ({1'b0, div_quo} + jac_pkg::VAL_UPPER) : {1'b0, div_quo};
    assign div_start = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis_sel  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (n_out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_left_raw  <= i_s_axis_tdata[15:0];
                        r_right_raw <= i_s_axis_tdata[31:16];
                        r_lo        <= n_lo;
                        r_hi        <= n_hi;
                        r_den_lo    <= n_lo - n_min;
                        r_den_hi    <= n_max - n_hi;
                        r_axis_sel  <= 1'b0;
                        r_state     <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_diff  <= n_diff[jac_pkg::DIFF_W-1:0];
                    r_den   <= n_den;
                    r_upper <= ~n_below;
                    if (!n_fixed) begin
                        r_state <= S_LOAD;
                    end else if (!r_axis_sel) begin
                        r_left_val <= jac_pkg::VAL_CENTER;
                        r_axis_sel <= 1'b1;
                    end else begin
                        r_right_val <= jac_pkg::VAL_CENTER;
                        r_state     <= S_DONE;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (!r_axis_sel) begin
                            r_left_val <= n_div_val;
                            r_axis_sel <= 1'b1;
                            r_state    <= S_PREP;
                        end else begin
                            r_right_val <= n_div_val;
                            r_state     <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // The result register is loaded only once the previous beat has left.
                    if (n_out_load) begin
                        r_out_data <= {6'b000000, right_click, left_click,
                                       right_pressed, left_pressed,
                                       r_right_val, r_left_val};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    jac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    jac_debounce u_left_btn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (n_accept),
        .i_level    (i_s_axis_tdata[32]),
        .i_now_ms   (i_s_axis_tdata[65:34]),
        .i_delay_ms (r_delay),
        .o_pressed  (left_pressed),
        .o_click    (left_click)
    );

    jac_debounce u_right_btn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (n_accept),
        .i_level    (i_s_axis_tdata[33]),
        .i_now_ms   (i_s_axis_tdata[65:34]),
        .i_delay_ms (r_delay),
        .o_pressed  (right_pressed),
        .o_click    (right_click)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // A result beat is loaded only from the final state of an item.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat appeared without a finished item");

    // Mapped axis values never leave the 0..2000 range.
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[10:0] <= jac_pkg::VAL_MAX)
                        && (r_out_data[21:11] <= jac_pkg::VAL_MAX))
        else $error("mapped axis value out of range");

    // A click is a release, so the button cannot be reported held at the same time.
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[24] && r_out_data[22])
                        && !(r_out_data[25] && r_out_data[23]))
        else $error("click reported while the button is held");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the joystick axis and button conditioner stream block.
`timescale 1ns / 1ps

import jac_pkg::*;

typedef struct {
    logic signed [RAW_W-1:0] left_raw;
    logic signed [RAW_W-1:0] right_raw;
    bit                      left_level;
    bit                      right_level;
    bit [TIME_W-1:0]         now_ms;
} poll_t;

typedef struct {
    bit [VAL_W-1:0] left_value;
    bit [VAL_W-1:0] right_value;
    bit             left_pressed;
    bit             right_pressed;
    bit             left_click;
    bit             right_click;
} stick_state_t;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

localparam int BUTTONS = 2;

// Tracks calibration and button history, and holds the stick states still owed by the block.
class stick_scoreboard;
    bit [CTR_W-1:0]   center;
    bit [DZ_W-1:0]    dead_zone;
    bit [CTR_W-1:0]   raw_min;
    bit [CTR_W-1:0]   raw_max;
    bit [DELAY_W-1:0] delay_ms;
    bit               stable[BUTTONS];
    bit               last_pressed[BUTTONS];
    bit [TIME_W-1:0]  change_time[BUTTONS];
    bit               reported[BUTTONS];
    stick_state_t     owed[$];
    int unsigned      mismatches;
    int unsigned      polls;
    int unsigned      clicks;

    function new();
        center    = RST_CENTER;
        dead_zone = RST_DEADZONE;
        raw_min   = RST_RAW_MIN;
        raw_max   = RST_RAW_MAX;
        delay_ms  = RST_DEBOUNCE;
        for (int b = 0; b < BUTTONS; b++) begin
            stable[b]       = 1'b0;
            last_pressed[b] = 1'b0;
            change_time[b]  = '0;
            reported[b]     = 1'b0;
        end
        mismatches = 0;
        polls      = 0;
        clicks     = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_CENTER:   center    = data[CTR_W-1:0];
            CFG_DEADZONE: dead_zone = data[DZ_W-1:0];
            CFG_RAW_MIN:  raw_min   = data[CTR_W-1:0];
            CFG_RAW_MAX:  raw_max   = data[CTR_W-1:0];
            CFG_DEBOUNCE: delay_ms  = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    // The band edges can fall outside the raw range, so all of this is done in 64 bits.
    function bit [VAL_W-1:0] axis_position(logic signed [RAW_W-1:0] raw);
        longint v, lo, hi, rmin, rmax, den, q;
        v    = raw;
        lo   = longint'(center) - longint'(dead_zone);
        hi   = longint'(center) + longint'(dead_zone);
        rmin = longint'(raw_min);
        rmax = longint'(raw_max);
        if (v >= lo && v <= hi)
            return VAL_CENTER;
        if (v < lo) begin
            if (v < rmin)
                v = rmin;
            den = lo - rmin;
            if (den <= 0)
                return VAL_CENTER;
            q = (v - rmin) * longint'(SCALE) / den;
        end else begin
            if (v > rmax)
                v = rmax;
            den = rmax - hi;
            if (den <= 0)
                return VAL_CENTER;
            q = (v - hi) * longint'(SCALE) / den + longint'(VAL_UPPER);
        end
        return q[VAL_W-1:0];
    endfunction

    function void note_poll(poll_t p);
        stick_state_t s;
        bit           pressed[BUTTONS];
        bit           click[BUTTONS];
        bit [TIME_W-1:0] elapsed;
        s.left_value  = axis_position(p.left_raw);
        s.right_value = axis_position(p.right_raw);
        pressed[0] = !p.left_level;
        pressed[1] = !p.right_level;
        for (int b = 0; b < BUTTONS; b++) begin
            if (pressed[b] != last_pressed[b])
                change_time[b] = p.now_ms;
            elapsed = p.now_ms - change_time[b];
            if (elapsed > delay_ms)
                stable[b] = pressed[b];
            last_pressed[b] = pressed[b];
            click[b]    = reported[b] && !stable[b];
            reported[b] = stable[b];
        end
        s.left_pressed  = stable[0];
        s.right_pressed = stable[1];
        s.left_click    = click[0];
        s.right_click   = click[1];
        owed.push_back(s);
        polls++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
        stick_state_t want;
        if (owed.size() == 0) begin
            mismatches++;
            $display("%0t: result beat %h expected none, got one", $time, data);
            return;
        end
        want = owed.pop_front();
        clicks += want.left_click + want.right_click;
        compare_field("left_axis_value", want.left_value, data[VAL_W-1:0]);
        compare_field("right_axis_value", want.right_value, data[2*VAL_W-1:VAL_W]);
        compare_field("left_pressed", want.left_pressed, data[2*VAL_W]);
        compare_field("right_pressed", want.right_pressed, data[2*VAL_W+1]);
        compare_field("left_click", want.left_click, data[2*VAL_W+2]);
        compare_field("right_click", want.right_click, data[2*VAL_W+3]);
    endfunction
endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASE_POLLS  = 134;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              m_tready = 1'b0;
    logic              cfg_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    stick_scoreboard   sb;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int unsigned       cycle_count = 0;
    int                settings = 1;
    bit [TIME_W-1:0]   now_ms = '0;
    bit                left_held = 1'b0;
    bit                right_held = 1'b0;

    joystick_axis_and_button_conditioner DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_wr_en    (cfg_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results owed",
                     cycle_count, sb.owed.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_poll(poll_t p);
        logic [IN_W-1:0] d;
        d = '0;
        d[RAW_W-1:0]           = p.left_raw;
        d[2*RAW_W-1:RAW_W]     = p.right_raw;
        d[2*RAW_W]             = p.left_level;
        d[2*RAW_W+1]           = p.right_level;
        d[2*RAW_W+2 +: TIME_W] = p.now_ms;
        return d;
    endfunction

    function automatic logic signed [RAW_W-1:0] clip_raw(longint x);
        if (x < -32768)
            return -16'sd32768;
        if (x > 32767)
            return 16'sd32767;
        return x[RAW_W-1:0];
    endfunction

    // Most samples land near a band edge or a clamp, since that is where the mapping bends.
    function automatic logic signed [RAW_W-1:0] pick_raw();
        longint lo, hi;
        lo = longint'(sb.center) - longint'(sb.dead_zone);
        hi = longint'(sb.center) + longint'(sb.dead_zone);
        case ($urandom_range(0, 9))
            0, 1, 2: return RAW_W'($urandom);
            3, 4:    return clip_raw(lo + $urandom_range(0, 80) - 40);
            5, 6:    return clip_raw(hi + $urandom_range(0, 80) - 40);
            7:       return clip_raw(longint'(sb.raw_min) + $urandom_range(0, 40) - 20);
            8:       return clip_raw(longint'(sb.raw_max) + $urandom_range(0, 40) - 20);
            default: return clip_raw(lo + $urandom_range(0, 2 * sb.dead_zone));
        endcase
    endfunction

    // Enters and leaves at a falling edge; tvalid stays up between back-to-back beats.
    task automatic send_poll(poll_t p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= pack_poll(p);
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_poll(p);
        @(negedge i_clk);
    endtask

    task automatic put_poll(int l, int r, bit ll, bit rl, bit [TIME_W-1:0] t);
        poll_t p;
        p.left_raw    = RAW_W'(l);
        p.right_raw   = RAW_W'(r);
        p.left_level  = ll;
        p.right_level = rl;
        p.now_ms      = t;
        send_poll(p);
    endtask

    // Buttons hold a level for a while with the odd one-poll bounce; time mostly
    // moves in steps scaled to the debounce delay so that presses get accepted.
    task automatic random_poll(logic signed [RAW_W-1:0] l, logic signed [RAW_W-1:0] r);
        int  pick;
        bit  ll, rl;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            now_ms += $urandom_range(1, sb.delay_ms / 4 + 4);
        else if (pick < 90)
            now_ms += $urandom_range(0, 3);
        else if (pick < 97)
            now_ms += sb.delay_ms + $urandom_range(0, 1);
        else
            now_ms = $urandom;
        if ($urandom_range(0, 11) == 0)
            left_held = !left_held;
        if ($urandom_range(0, 11) == 0)
            right_held = !right_held;
        ll = !left_held;
        rl = !right_held;
        if ($urandom_range(0, 19) == 0)
            ll = !ll;
        if ($urandom_range(0, 19) == 0)
            rl = !rl;
        put_poll(l, r, ll, rl, now_ms);
    endtask

    // The last beat is withdrawn first so that the block does not take it a second time.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 85; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            IDLE_BOTH:     begin send_idle_pct = 28; recv_stall_pct = 28; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Called only with nothing in flight; unused indexes get junk that must be ignored.
    task automatic calibrate(logic [CFG_W-1:0] c, logic [CFG_W-1:0] dz,
                             logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx,
                             logic [CFG_W-1:0] dly);
        for (int k = CFG_DEBOUNCE + 1; k < (1 << IDX_W); k++)
            cfg_write(IDX_W'(k), CFG_W'($urandom));
        cfg_write(CFG_CENTER, c);
        cfg_write(CFG_DEADZONE, dz);
        cfg_write(CFG_RAW_MIN, mn);
        cfg_write(CFG_RAW_MAX, mx);
        cfg_write(CFG_DEBOUNCE, dly);
        cfg_en <= 1'b0;
        @(negedge i_clk);
        settings++;
    endtask

    task automatic run_phase(idle_mode_e mode);
        longint lo, hi;
        set_idle(mode);
        lo = longint'(sb.center) - longint'(sb.dead_zone);
        hi = longint'(sb.center) + longint'(sb.dead_zone);
        random_poll(clip_raw(lo - 1), clip_raw(hi + 1));
        random_poll(clip_raw(lo), clip_raw(hi));
        random_poll(clip_raw(longint'(sb.raw_min) - 1), clip_raw(longint'(sb.raw_max) + 1));
        random_poll(-16'sd32768, 16'sd32767);
        for (int n = 0; n < PHASE_POLLS; n++)
            random_poll(pick_raw(), pick_raw());
        drain();
    endtask

    initial begin
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default calibration: range extremes, band edges and clamps, then button timing.
        set_idle(IDLE_NONE);
        put_poll(-32768, 32767, 1'b1, 1'b1, 32'd10);
        put_poll(0, 23500, 1'b1, 1'b1, 32'd20);
        put_poll(11270, 12470, 1'b1, 1'b1, 32'd30);
        put_poll(11269, 12471, 1'b1, 1'b1, 32'd40);
        put_poll(-1, 23499, 1'b1, 1'b1, 32'd50);
        put_poll(5000, 20000, 1'b0, 1'b1, 32'd100);
        // Exactly the delay has passed here, which is not yet enough.
        put_poll(11269, 12471, 1'b0, 1'b0, 32'd150);
        put_poll(1, 23000, 1'b0, 1'b0, 32'd151);
        put_poll(7000, 15000, 1'b0, 1'b1, 32'd201);
        put_poll(11870, 12470, 1'b1, 1'b1, 32'd260);
        put_poll(11270, 32000, 1'b1, 1'b1, 32'd311);
        // Press just before the timestamp wraps and release on the far side of it.
        put_poll(300, 30000, 1'b0, 1'b0, 32'hFFFF_FFF0);
        put_poll(-300, 16000, 1'b0, 1'b0, 32'h0000_0030);
        put_poll(11000, 13000, 1'b1, 1'b1, 32'h0000_0040);
        put_poll(9000, 14000, 1'b1, 1'b1, 32'h0000_0080);
        now_ms = 32'h0000_0080;
        drain();

        run_phase(IDLE_SENDER);
        calibrate(16'd0, 16'd0, 16'd0, 16'd32767, 16'd0);
        run_phase(IDLE_RECEIVER);
        calibrate(16'd32767, 16'd16383, 16'd32767, 16'd32767, 16'd65535);
        run_phase(IDLE_BOTH);
        // Upper register bits beyond each width must be dropped; the lower band edge
        // goes negative and both spans come out non-positive.
        calibrate(16'h8064, 16'hFFFF, 16'h8000, 16'hBE80, 16'd1);
        run_phase(IDLE_NONE);
        calibrate(16'd16000, 16'd200, 16'd1000, 16'd30000, 16'd20);
        now_ms = 32'hFFFF_FF00;
        run_phase(IDLE_SENDER);
        calibrate(16'd5000, 16'd5000, 16'd0, 16'd20000, 16'd7);
        run_phase(IDLE_RECEIVER);
        calibrate(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                  CFG_W'($urandom_range(0, 300)));
        run_phase(IDLE_BOTH);
        calibrate(CFG_W'($urandom), CFG_W'($urandom_range(0, 3000)),
                  CFG_W'($urandom_range(0, 12000)),
                  CFG_W'($urandom_range(12000, 32767)), CFG_W'($urandom));
        run_phase(IDLE_NONE);
        drain();

        $display("Ran %0d polls through %0d calibration settings and four idle patterns,",
                 sb.polls, settings);
        $display("with %0d button clicks checked and %0d mismatches.", sb.clicks, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
